>>> sv/nvp_pkg.sv
// shared types and constants for the name-value pair stream parser
package nvp_pkg;

  localparam int unsigned LEN_W = 31;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned SUM_W = LEN_W + 2;

  typedef enum logic [2:0] {
    PH_KEYLEN  = 3'd0,
    PH_VALLEN  = 3'd1,
    PH_KEY     = 3'd2,
    PH_VALUE   = 3'd3,
    PH_DISCARD = 3'd4
  } phase_t;

  localparam logic [2:0] KIND_KEYLEN  = 3'd0;
  localparam logic [2:0] KIND_VALLEN  = 3'd1;
  localparam logic [2:0] KIND_KEY     = 3'd2;
  localparam logic [2:0] KIND_VALUE   = 3'd3;
  localparam logic [2:0] KIND_DISCARD = 3'd4;

  localparam logic [1:0] LAST_LEN_BYTE = 2'd3;

  typedef struct packed {
    phase_t           phase;
    logic [LEN_W-1:0] acc;
    logic [1:0]       cnt;
    logic [LEN_W-1:0] key_len;
    logic [LEN_W-1:0] val_len;
    logic [LEN_W-1:0] remaining;
  } nvp_state_t;

  typedef struct packed {
    logic [7:0]       byte_value;
    logic [2:0]       byte_kind;
    logic [LEN_W-1:0] key_length;
    logic [LEN_W-1:0] value_length;
    logic             pair_done;
    logic             length_error;
  } nvp_result_t;

endpackage

>>> sv/nvp_step.sv
// per-word parser update: next state and tagged result from current state and input word
module nvp_step (
  input  nvp_pkg::nvp_state_t  state_i,
  input  logic [7:0]           byte_i,
  input  logic                 start_i,
  input  logic [15:0]          max_len_i,
  output nvp_pkg::nvp_state_t  state_o,
  output nvp_pkg::nvp_result_t result_o
);
  import nvp_pkg::*;

  nvp_state_t       cur;
  logic             len_done;
  logic [LEN_W-1:0] len_val;
  logic [LEN_W-1:0] acc_upd;
  logic [1:0]       cnt_upd;
  logic [LEN_W-1:0] shifted;
  logic [LEN_W-1:0] rem_dec;
  logic [SUM_W-1:0] total;
  logic             over_limit;
  logic [2:0]       kind;
  logic             done;
  logic             err;

  // record start restarts the parser, a fresh pair clears the shown lengths
  always_comb begin
    cur = state_i;
    if (start_i) begin
      cur.phase     = PH_KEYLEN;
      cur.acc       = '0;
      cur.cnt       = '0;
      cur.remaining = '0;
    end
    if (cur.phase == PH_KEYLEN && cur.cnt == 2'd0) begin
      cur.key_len = '0;
      cur.val_len = '0;
    end
  end

  assign shifted = {cur.acc[LEN_W-9:0], byte_i};

  // one or four byte length, top bit of the first byte selects the long form
  always_comb begin
    len_done = 1'b0;
    len_val  = '0;
    acc_upd  = cur.acc;
    cnt_upd  = cur.cnt;
    if (cur.cnt == 2'd0) begin
      if (!byte_i[7]) begin
        len_done = 1'b1;
        len_val  = {{(LEN_W-8){1'b0}}, byte_i};
      end else begin
        acc_upd = {{(LEN_W-7){1'b0}}, byte_i[6:0]};
        cnt_upd = 2'd1;
      end
    end else if (cur.cnt == LAST_LEN_BYTE) begin
      len_done = 1'b1;
      len_val  = shifted;
      acc_upd  = '0;
      cnt_upd  = 2'd0;
    end else begin
      acc_upd = shifted;
      cnt_upd = cur.cnt + 2'd1;
    end
  end

  assign rem_dec    = cur.remaining - {{(LEN_W-1){1'b0}}, 1'b1};
  assign total      = {2'b00, cur.key_len} + {2'b00, len_val} + SUM_W'(HEADER_BYTES);
  assign over_limit = total > {{(SUM_W-16){1'b0}}, max_len_i};

  // next state
  always_comb begin
    state_o = cur;
    unique case (cur.phase)
      PH_KEYLEN: begin
        state_o.acc = acc_upd;
        state_o.cnt = cnt_upd;
        if (len_done) begin
          state_o.key_len = len_val;
          state_o.phase   = PH_VALLEN;
        end
      end
      PH_VALLEN: begin
        state_o.acc = acc_upd;
        state_o.cnt = cnt_upd;
        if (len_done) begin
          state_o.val_len = len_val;
          if (over_limit) begin
            state_o.phase = PH_DISCARD;
          end else if (cur.key_len != '0) begin
            state_o.remaining = cur.key_len;
            state_o.phase     = PH_KEY;
          end else if (len_val != '0) begin
            state_o.remaining = len_val;
            state_o.phase     = PH_VALUE;
          end else begin
            state_o.phase = PH_KEYLEN;
          end
        end
      end
      PH_KEY: begin
        state_o.remaining = rem_dec;
        if (rem_dec == '0) begin
          if (cur.val_len != '0) begin
            state_o.remaining = cur.val_len;
            state_o.phase     = PH_VALUE;
          end else begin
            state_o.phase = PH_KEYLEN;
          end
        end
      end
      PH_VALUE: begin
        state_o.remaining = rem_dec;
        if (rem_dec == '0) begin
          state_o.phase = PH_KEYLEN;
        end
      end
      default: begin
        state_o.phase = PH_DISCARD;
      end
    endcase
  end

  // result tagging
  always_comb begin
    kind = KIND_DISCARD;
    done = 1'b0;
    err  = 1'b0;
    unique case (cur.phase)
      PH_KEYLEN: begin
        kind = KIND_KEYLEN;
      end
      PH_VALLEN: begin
        kind = KIND_VALLEN;
        err  = len_done && over_limit;
        done = len_done && !over_limit && cur.key_len == '0 && len_val == '0;
      end
      PH_KEY: begin
        kind = KIND_KEY;
        done = rem_dec == '0 && cur.val_len == '0;
      end
      PH_VALUE: begin
        kind = KIND_VALUE;
        done = rem_dec == '0;
      end
      default: begin
        kind = KIND_DISCARD;
      end
    endcase
  end

  assign result_o.byte_value   = byte_i;
  assign result_o.byte_kind    = kind;
  assign result_o.key_length   = state_o.key_len;
  assign result_o.value_length = state_o.val_len;
  assign result_o.pair_done    = done;
  assign result_o.length_error = err;

endmodule

>>> sv/nvp_out_buf.sv
// two-entry output register with skid stage for result words
module nvp_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  nvp_pkg::nvp_result_t data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 pop_ready_i,
  output nvp_pkg::nvp_result_t data_o
);
  import nvp_pkg::*;

  nvp_result_t out_r;
  nvp_result_t out_nxt;
  nvp_result_t skid_r;
  nvp_result_t skid_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        skid_valid_r;
  logic        skid_valid_nxt;
  logic        pop;

  assign pop     = out_valid_r && pop_ready_i;
  assign ready_o = !skid_valid_r;
  assign valid_o = out_valid_r;
  assign data_o  = out_r;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (push_i && (!out_valid_r || pop)) begin
      out_nxt       = data_i;
      out_valid_nxt = 1'b1;
    end else if (push_i) begin
      // receiver stalled, park the word
      skid_nxt       = data_i;
      skid_valid_nxt = 1'b1;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  a_skid_drains_first: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (out_valid_r && !skid_valid_r && out_r == $past(skid_r)))
    else $error("skid word not moved to output");

  a_stall_keeps_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop_ready_i) |=> (out_valid_r && $stable(out_r)))
    else $error("output word changed while stalled");

endmodule

>>> sv/name_value_pair_stream_parser.sv
// top level of the name-value pair stream parser
// Decodes the content bytes of a params record, one byte per input word.
// in channel: in_tdata carries the byte, in_tuser flags the first byte of a
// new record, which restarts the parser at a key length.
// out channel: one word per input word, the byte tagged with its kind
// (key length, value length, key, value, discarded), the decoded key and
// value lengths once known, tlast on the last byte of a complete pair and
// an error flag on the last value-length byte of a pair over the limit.
// After an error, bytes are tagged discarded until the next record start.
// cfg port: cfg_wr_en with cfg_wr_data sets the record length limit, header
// included; the user must write it only while the block is idle, as the
// block itself does not enforce this. Throughput is one word per cycle
// while in_tready is high: the parser state is updated by one pass of
// combinational logic per accepted word.
// Results sit in an output register backed by a skid stage, so one more word
// is taken while the receiver stalls; in_tready drops once both are full.
// Synchronous reset empties both stages, puts the parser at a key length
// and sets the limit to 65535.
module name_value_pair_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] param_byte
  input  logic [0:0]  in_tuser,   // [0] record_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] byte_value, [38:8] key_length, [69:39] value_length, [71:70] zero
  output logic [71:0] out_tdata,
  output logic [3:0]  out_tuser,  // [2:0] byte_kind, [3] length_error
  output logic        out_tlast,  // pair_done
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import nvp_pkg::*;

  nvp_state_t  state_r;
  nvp_state_t  state_nxt;
  nvp_result_t step_res;
  nvp_result_t out_res;
  logic [15:0] max_len_r;
  logic        accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  nvp_step u_step (
    .state_i  (state_r),
    .byte_i   (in_tdata),
    .start_i  (in_tuser[0]),
    .max_len_i(max_len_r),
    .state_o  (state_nxt),
    .result_o (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_KEYLEN, default: '0};
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  nvp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (accept),
    .data_i     (step_res),
    .ready_o    (in_tready),
    .valid_o    (out_tvalid),
    .pop_ready_i(out_tready),
    .data_o     (out_res)
  );

  assign out_tdata = {2'b00, out_res.value_length, out_res.key_length, out_res.byte_value};
  assign out_tuser = {out_res.length_error, out_res.byte_kind};
  assign out_tlast = out_res.pair_done;

  a_error_enters_discard: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && step_res.length_error) |=> state_r.phase == PH_DISCARD)
    else $error("length error without discard");

  a_discard_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && state_r.phase == PH_DISCARD && !in_tuser[0]) |=> state_r.phase == PH_DISCARD)
    else $error("discard left without record start");

  a_count_only_in_lengths: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.cnt != 2'd0) |-> (state_r.phase == PH_KEYLEN || state_r.phase == PH_VALLEN))
    else $error("length byte count outside a length field");

endmodule
